// ===== src/ps2m_pkg.sv =====
`timescale 1ns / 1ps

package ps2m_pkg;

    localparam int unsigned DATA_PRESENT_BIT = 5;
    localparam int unsigned BUTTON_COUNT     = 3;
    localparam logic [1:0]  POS_LAST         = 2'd2;

    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_event_kind;

    // events caused by one completed packet
    typedef struct packed {
        logic                    has_move;
        logic [BUTTON_COUNT-1:0] btn_change;
        logic [BUTTON_COUNT-1:0] old_btn;
        logic signed [7:0]       dx;
        logic signed [7:0]       dy;
    } t_bundle;

    typedef struct packed {
        t_event_kind       kind;
        logic [1:0]        button;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic              last;
    } t_event;

endpackage

// ===== src/ps2m_decode.sv =====
`timescale 1ns / 1ps

module ps2m_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  logic              i_accept,
    input  logic [7:0]        i_status_byte,
    input  logic [7:0]        i_data_byte,
    output ps2m_pkg::t_bundle o_bundle
);

    logic                                r_events_enabled;
    logic [7:0]                          r_pkt0;
    logic [7:0]                          r_pkt1;
    logic [1:0]                          r_pos;
    logic [ps2m_pkg::BUTTON_COUNT-1:0]   r_buttons;
    logic                                take;
    logic                                at_last;

    assign take    = i_accept && r_events_enabled
                     && i_status_byte[ps2m_pkg::DATA_PRESENT_BIT];
    assign at_last = (r_pos == ps2m_pkg::POS_LAST);

    always_comb begin
        o_bundle.has_move   = take && at_last && ((r_pkt1 != 8'd0) || (i_data_byte != 8'd0));
        o_bundle.btn_change = r_pkt0[ps2m_pkg::BUTTON_COUNT-1:0] ^ r_buttons;
        o_bundle.old_btn    = r_buttons;
        o_bundle.dx         = r_pkt1;
        o_bundle.dy         = 8'(8'd0 - i_data_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_events_enabled <= 1'b1;
            r_pos            <= 2'd0;
            r_buttons        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_events_enabled <= i_cfg_data;
            end
            if (take) begin
                if (at_last) begin
                    r_pos <= 2'd0;
                    if (o_bundle.has_move) begin
                        r_buttons <= r_pkt0[ps2m_pkg::BUTTON_COUNT-1:0];
                    end
                end else if (r_pos == 2'd1) begin
                    r_pos <= 2'd2;
                end else begin
                    // position three is unreachable and acts as zero
                    r_pos <= 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !at_last) begin
            if (r_pos == 2'd1) begin
                r_pkt1 <= i_data_byte;
            end else begin
                r_pkt0 <= i_data_byte;
            end
        end
    end

endmodule

// ===== src/ps2m_serializer.sv =====
`timescale 1ns / 1ps

module ps2m_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ps2m_pkg::t_bundle i_bundle,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output ps2m_pkg::t_event  o_event,
    output logic              o_can_load
);

    logic                              r_move_pend;
    logic [ps2m_pkg::BUTTON_COUNT-1:0] r_btn_pend;
    logic [ps2m_pkg::BUTTON_COUNT-1:0] r_old_btn;
    logic signed [7:0]                 r_dx;
    logic signed [7:0]                 r_dy;
    logic [ps2m_pkg::BUTTON_COUNT-1:0] lowest;
    logic [ps2m_pkg::BUTTON_COUNT-1:0] btn_rest;
    logic [1:0]                        btn_num;
    logic                              done;

    // isolate lowest pending button
    assign lowest   = r_btn_pend & (~r_btn_pend + 1'b1);
    assign btn_rest = r_btn_pend & ~lowest;

    always_comb begin
        btn_num = 2'd0;
        for (int i = ps2m_pkg::BUTTON_COUNT - 1; i >= 0; i--) begin
            if (lowest[i]) begin
                btn_num = 2'(i + 1);
            end
        end
    end

    always_comb begin
        if (r_move_pend) begin
            o_event.kind   = ps2m_pkg::EV_MOVE;
            o_event.button = 2'd0;
            o_event.dx     = r_dx;
            o_event.dy     = r_dy;
            o_event.last   = (r_btn_pend == '0);
        end else begin
            o_event.kind   = ((r_old_btn & lowest) != '0) ? ps2m_pkg::EV_RELEASE
                                                          : ps2m_pkg::EV_PRESS;
            o_event.button = btn_num;
            o_event.dx     = 8'sd0;
            o_event.dy     = 8'sd0;
            o_event.last   = (btn_rest == '0);
        end
    end

    assign o_out_valid = r_move_pend || (r_btn_pend != '0);
    assign done        = o_out_valid && i_out_ready && o_event.last;
    assign o_can_load  = !o_out_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_pend <= 1'b0;
            r_btn_pend  <= '0;
        end else if (i_load) begin
            r_move_pend <= i_bundle.has_move;
            r_btn_pend  <= i_bundle.has_move ? i_bundle.btn_change : '0;
        end else if (o_out_valid && i_out_ready) begin
            if (r_move_pend) begin
                r_move_pend <= 1'b0;
            end else begin
                r_btn_pend <= btn_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_old_btn <= i_bundle.old_btn;
            r_dx      <= i_bundle.dx;
            r_dy      <= i_bundle.dy;
        end
    end

endmodule

// ===== src/ps2_mouse_packet_decoder.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/tready         tdata: status_byte, data_byte
// m_axis    out  m_axis_tvalid/tready         tuser: event_kind
//                                             tdata: button_number, delta_x, delta_y
//                                             tlast: last
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_data: events_enabled
//
// One input transaction per cycle is taken. A packet with movement yields 1 to 4
// events from the event register, the first valid the cycle after the final byte
// is taken, then one per cycle as the output port accepts them.
// Input stalls while the event register holds events, except in the cycle its
// final event leaves. Both ready outputs are low during reset.
// Synchronous active-low reset: position 0, buttons released, delivery on.

module ps2_mouse_packet_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] status_byte, [15:8] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] button_number, [9:2] delta_x, [17:10] delta_y
    output logic [23:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    ps2m_pkg::t_bundle bundle;
    ps2m_pkg::t_event  ev;
    logic              can_load;
    logic              accept;

    assign s_axis_tready = can_load && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = i_rst_n;

    ps2m_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_status_byte (s_axis_tdata[7:0]),
        .i_data_byte   (s_axis_tdata[15:8]),
        .o_bundle      (bundle)
    );

    ps2m_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && bundle.has_move),
        .i_bundle    (bundle),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_event     (ev),
        .o_can_load  (can_load)
    );

    assign m_axis_tdata = {6'd0, ev.dy, ev.dx, ev.button};
    assign m_axis_tuser = ev.kind;
    assign m_axis_tlast = ev.last;

endmodule
